/* rtl/ovls_pkg.sv */
// Shared types and constants of the ordered value list store.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package ovls_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 3;

  localparam int unsigned GRP_SIZE  = 8;
  localparam int unsigned SUB_W     = $clog2(GRP_SIZE);
  localparam int unsigned GRP_CNT   = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned GRP_IDX_W = (GRP_CNT > 1) ? $clog2(GRP_CNT) : 1;
  localparam int unsigned PAD_W     = GRP_CNT * GRP_SIZE;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_PUSH   = 3'd1,
    CMD_POP    = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_FIND   = 3'd4,
    CMD_MODIFY = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_WRITE = 3'd1,
    CELL_SHR   = 3'd2,
    CELL_SHL   = 3'd3,
    CELL_MATCH = 3'd4,
    CELL_KEEP  = 3'd5,
    CELL_SORT  = 3'd6
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  sel;
    logic [DATA_W-1:0] data;
    logic              parity;
  } cell_ctrl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } first_hit_t;

endpackage

`default_nettype wire

/* rtl/ovls_cell.sv */
// One storage cell of the list: an entry, a flag and the moves to its neighbors.
// Depends on ovls_pkg.
`default_nettype none

module ovls_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ovls_pkg::IDX_W-1:0]   idx_i,
  input  logic [ovls_pkg::CNT_W-1:0]   count_i,
  input  ovls_pkg::cell_ctrl_t         ctrl_i,
  input  logic [ovls_pkg::DATA_W-1:0]  left_value_i,
  input  logic                         left_flag_i,
  input  logic [ovls_pkg::DATA_W-1:0]  right_value_i,
  input  logic                         right_flag_i,
  output logic [ovls_pkg::DATA_W-1:0]  value_o,
  output logic                         flag_o
);

  logic [ovls_pkg::DATA_W-1:0] value_q, value_d;
  logic                        flag_q, flag_d;
  logic                        in_use;
  logic                        is_match;
  logic                        left_member;

  assign in_use      = ovls_pkg::CNT_W'(idx_i) < count_i;
  assign is_match    = in_use && (value_q == ctrl_i.data);
  assign left_member = (idx_i[0] == ctrl_i.parity);

  always_comb begin
    value_d = value_q;
    flag_d  = flag_q;
    unique case (ctrl_i.op)
      ovls_pkg::CELL_WRITE: begin
        if (idx_i == ctrl_i.sel) begin
          value_d = ctrl_i.data;
        end
      end
      ovls_pkg::CELL_SHR: begin
        value_d = left_value_i;
      end
      ovls_pkg::CELL_SHL: begin
        value_d = right_value_i;
      end
      ovls_pkg::CELL_MATCH: begin
        flag_d = is_match;
      end
      ovls_pkg::CELL_KEEP: begin
        flag_d = in_use && !is_match;
      end
      ovls_pkg::CELL_SORT: begin
        // A kept entry trades places with a hole on its left.
        if (left_member) begin
          if (!flag_q && right_flag_i) begin
            value_d = right_value_i;
            flag_d  = 1'b1;
          end
        end else begin
          if (!left_flag_i && flag_q) begin
            value_d = left_value_i;
            flag_d  = 1'b0;
          end
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign value_o = value_q;
  assign flag_o  = flag_q;

endmodule

`default_nettype wire

/* rtl/ovls_first_hit.sv */
// Two-stage registered search for the lowest set bit of the cell flag vector.
// Depends on ovls_pkg.
`default_nettype none

module ovls_first_hit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ovls_pkg::DEPTH-1:0]  vec_i,
  output ovls_pkg::first_hit_t        hit_o
);

  logic [ovls_pkg::PAD_W-1:0]   padded;
  logic [ovls_pkg::GRP_CNT-1:0] grp_any_d, grp_any_q;
  logic [ovls_pkg::SUB_W-1:0]   grp_sub_d [ovls_pkg::GRP_CNT];
  logic [ovls_pkg::SUB_W-1:0]   grp_sub_q [ovls_pkg::GRP_CNT];
  ovls_pkg::first_hit_t         hit_d, hit_q;

  assign padded = ovls_pkg::PAD_W'(vec_i);

  always_comb begin
    for (int g = 0; g < ovls_pkg::GRP_CNT; g++) begin
      grp_any_d[g] = 1'b0;
      grp_sub_d[g] = '0;
      for (int s = ovls_pkg::GRP_SIZE - 1; s >= 0; s--) begin
        if (padded[g * ovls_pkg::GRP_SIZE + s]) begin
          grp_any_d[g] = 1'b1;
          grp_sub_d[g] = ovls_pkg::SUB_W'(s);
        end
      end
    end
  end

  always_comb begin
    logic [ovls_pkg::GRP_IDX_W+ovls_pkg::SUB_W-1:0] pad_idx;
    pad_idx     = '0;
    hit_d.found = 1'b0;
    for (int g = ovls_pkg::GRP_CNT - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        hit_d.found = 1'b1;
        pad_idx     = {ovls_pkg::GRP_IDX_W'(g), grp_sub_q[g]};
      end
    end
    hit_d.idx = ovls_pkg::IDX_W'(pad_idx);
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < ovls_pkg::GRP_CNT; g++) begin
      grp_sub_q[g] <= grp_sub_d[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_any_q <= '0;
      hit_q     <= '0;
    end else begin
      grp_any_q <= grp_any_d;
      hit_q     <= hit_d;
    end
  end

  assign hit_o = hit_q;

endmodule

`default_nettype wire

/* rtl/ordered_value_list_store_unit.sv */
// Top level of the ordered value list store: command sequencer and the row of cells.
// Depends on ovls_pkg, ovls_cell and ovls_first_hit.
//
//   Channel   Handshake          Payload
//   command   start / busy       command_i, key_value_i, replacement_value_i
//   result    done_o (strobe)    status_o, popped_value_o, position_o,
//                                removed_count_o, entry_count_o
//
// Append, push, pop, unused codes and every full or empty refusal are answered from S_IDLE.
// Find and modify wait on the two-stage first-hit search; modify searches again unless it finds a duplicate.
// Delete first runs odd-even swap phases of the cell row in S_SORT until no inversion is left.
// Reset empties the list at once; the entries themselves are not cleared.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module ordered_value_list_store_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ovls_pkg::CMD_W-1:0]          command_i,
  input  logic signed [ovls_pkg::DATA_W-1:0]  key_value_i,
  input  logic signed [ovls_pkg::DATA_W-1:0]  replacement_value_i,
  output logic                                done_o,
  output logic [ovls_pkg::STATUS_W-1:0]       status_o,
  output logic signed [ovls_pkg::DATA_W-1:0]  popped_value_o,
  output logic [ovls_pkg::IDX_W-1:0]          position_o,
  output logic [ovls_pkg::CNT_W-1:0]          removed_count_o,
  output logic [ovls_pkg::CNT_W-1:0]          entry_count_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SORT  = 5'b00010,
    S_ENC_A = 5'b00100,
    S_ENC_B = 5'b01000,
    S_CHECK = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    PASS_FIND = 2'd0,
    PASS_DUP  = 2'd1,
    PASS_KEY  = 2'd2,
    PASS_DEL  = 2'd3
  } pass_e;

  state_e                        state_q, state_d;
  pass_e                         pass_q, pass_d;
  logic [ovls_pkg::DATA_W-1:0]   key_q, key_d;
  logic [ovls_pkg::DATA_W-1:0]   repl_q, repl_d;
  logic [ovls_pkg::CNT_W-1:0]    count_q, count_d;
  logic                          parity_q, parity_d;

  logic                          done_q, done_d;
  ovls_pkg::status_e             status_q, status_d;
  logic [ovls_pkg::DATA_W-1:0]   popped_q, popped_d;
  logic [ovls_pkg::IDX_W-1:0]    pos_q, pos_d;
  logic [ovls_pkg::CNT_W-1:0]    removed_q, removed_d;

  ovls_pkg::cell_ctrl_t          cell_ctrl;
  logic [ovls_pkg::DATA_W-1:0]   cell_value [ovls_pkg::DEPTH];
  logic [ovls_pkg::DEPTH-1:0]    cell_flag;
  logic [ovls_pkg::DEPTH-1:0]    search_vec;
  ovls_pkg::first_hit_t          hit;
  logic                          inversion;
  logic                          is_full;
  logic                          is_empty;
  logic [ovls_pkg::CNT_W-1:0]    new_len;

  for (genvar j = 0; j < ovls_pkg::DEPTH; j++) begin : g_cell
    logic [ovls_pkg::DATA_W-1:0] left_value;
    logic                        left_flag;
    logic [ovls_pkg::DATA_W-1:0] right_value;
    logic                        right_flag;

    if (j == 0) begin : g_head
      assign left_value = cell_ctrl.data;
      assign left_flag  = 1'b1;
    end else begin : g_inner_l
      assign left_value = cell_value[j-1];
      assign left_flag  = cell_flag[j-1];
    end

    if (j == ovls_pkg::DEPTH - 1) begin : g_tail
      assign right_value = cell_ctrl.data;
      assign right_flag  = 1'b0;
    end else begin : g_inner_r
      assign right_value = cell_value[j+1];
      assign right_flag  = cell_flag[j+1];
    end

    ovls_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .idx_i         (ovls_pkg::IDX_W'(j)),
      .count_i       (count_q),
      .ctrl_i        (cell_ctrl),
      .left_value_i  (left_value),
      .left_flag_i   (left_flag),
      .right_value_i (right_value),
      .right_flag_i  (right_flag),
      .value_o       (cell_value[j]),
      .flag_o        (cell_flag[j])
    );
  end

  // During delete the flags mark kept entries, so the search looks for the first hole.
  assign search_vec = cell_flag ^ {ovls_pkg::DEPTH{pass_q == PASS_DEL}};

  ovls_first_hit u_first_hit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vec_i  (search_vec),
    .hit_o  (hit)
  );

  assign inversion = |(~cell_flag[ovls_pkg::DEPTH-2:0] & cell_flag[ovls_pkg::DEPTH-1:1]);
  assign is_full   = (count_q == ovls_pkg::CNT_W'(ovls_pkg::DEPTH));
  assign is_empty  = (count_q == '0);
  assign new_len   = hit.found ? ovls_pkg::CNT_W'(hit.idx) : ovls_pkg::CNT_W'(ovls_pkg::DEPTH);

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    key_d     = key_q;
    repl_d    = repl_q;
    count_d   = count_q;
    parity_d  = parity_q;

    done_d    = 1'b0;
    status_d  = ovls_pkg::ST_OK;
    popped_d  = '0;
    pos_d     = '0;
    removed_d = '0;

    cell_ctrl.op     = ovls_pkg::CELL_HOLD;
    cell_ctrl.sel    = '0;
    cell_ctrl.data   = key_q;
    cell_ctrl.parity = parity_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          key_d          = key_value_i;
          repl_d         = replacement_value_i;
          cell_ctrl.data = key_value_i;
          unique case (command_i)
            ovls_pkg::CMD_APPEND: begin
              done_d = 1'b1;
              if (is_full) begin
                status_d = ovls_pkg::ST_FULL;
              end else begin
                cell_ctrl.op  = ovls_pkg::CELL_WRITE;
                cell_ctrl.sel = ovls_pkg::IDX_W'(count_q);
                count_d       = count_q + ovls_pkg::CNT_W'(1);
              end
            end
            ovls_pkg::CMD_PUSH: begin
              done_d = 1'b1;
              if (is_full) begin
                status_d = ovls_pkg::ST_FULL;
              end else begin
                cell_ctrl.op = ovls_pkg::CELL_SHR;
                count_d      = count_q + ovls_pkg::CNT_W'(1);
              end
            end
            ovls_pkg::CMD_POP: begin
              done_d = 1'b1;
              if (is_empty) begin
                status_d = ovls_pkg::ST_EMPTY;
              end else begin
                cell_ctrl.op = ovls_pkg::CELL_SHL;
                popped_d     = cell_value[0];
                count_d      = count_q - ovls_pkg::CNT_W'(1);
              end
            end
            ovls_pkg::CMD_DELETE: begin
              if (is_empty) begin
                done_d   = 1'b1;
                status_d = ovls_pkg::ST_EMPTY;
              end else begin
                cell_ctrl.op = ovls_pkg::CELL_KEEP;
                pass_d       = PASS_DEL;
                parity_d     = 1'b0;
                state_d      = S_SORT;
              end
            end
            ovls_pkg::CMD_FIND: begin
              cell_ctrl.op = ovls_pkg::CELL_MATCH;
              pass_d       = PASS_FIND;
              state_d      = S_ENC_A;
            end
            ovls_pkg::CMD_MODIFY: begin
              cell_ctrl.op   = ovls_pkg::CELL_MATCH;
              cell_ctrl.data = replacement_value_i;
              pass_d         = PASS_DUP;
              state_d        = S_ENC_A;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_SORT: begin
        if (inversion) begin
          cell_ctrl.op = ovls_pkg::CELL_SORT;
          parity_d     = ~parity_q;
        end else begin
          state_d = S_ENC_A;
        end
      end
      S_ENC_A: begin
        state_d = S_ENC_B;
      end
      S_ENC_B: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_IDLE;
        unique case (pass_q)
          PASS_FIND: begin
            done_d = 1'b1;
            if (hit.found) begin
              pos_d = hit.idx;
            end else begin
              status_d = ovls_pkg::ST_NOT_FOUND;
            end
          end
          PASS_DUP: begin
            if (hit.found) begin
              done_d   = 1'b1;
              status_d = ovls_pkg::ST_DUPLICATE;
            end else begin
              cell_ctrl.op   = ovls_pkg::CELL_MATCH;
              cell_ctrl.data = key_q;
              pass_d         = PASS_KEY;
              state_d        = S_ENC_A;
            end
          end
          PASS_KEY: begin
            done_d = 1'b1;
            if (hit.found) begin
              cell_ctrl.op   = ovls_pkg::CELL_WRITE;
              cell_ctrl.sel  = hit.idx;
              cell_ctrl.data = repl_q;
              pos_d          = hit.idx;
            end else begin
              status_d = ovls_pkg::ST_NOT_FOUND;
            end
          end
          PASS_DEL: begin
            done_d    = 1'b1;
            removed_d = count_q - new_len;
            count_d   = new_len;
            if (count_q == new_len) begin
              status_d = ovls_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    repl_q    <= repl_d;
    status_q  <= status_d;
    popped_q  <= popped_d;
    pos_q     <= pos_d;
    removed_q <= removed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pass_q   <= PASS_FIND;
      count_q  <= '0;
      parity_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      pass_q   <= pass_d;
      count_q  <= count_d;
      parity_q <= parity_d;
      done_q   <= done_d;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign popped_value_o  = popped_q;
  assign position_o      = pos_q;
  assign removed_count_o = removed_q;
  assign entry_count_o   = count_q;

endmodule

`default_nettype wire
